// ===== hdl/ncp_pkg.sv =====
package ncp_pkg;

  localparam int IDX_W   = 10;
  localparam int COUNT_W = 32;
  localparam int TIME_W  = 48;
  localparam int DEPTH_W = 8;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_OVERFLOW  = 3'd1,
    ERR_UNDERFLOW = 3'd2,
    ERR_FULL      = 3'd3,
    ERR_UNKNOWN   = 3'd4
  } err_t;

  typedef struct packed {
    logic               action;
    logic               is_new;
    logic [IDX_W-1:0]   record_index;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  now_time;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   record_out;
    logic [COUNT_W-1:0] call_count;
    logic [TIME_W-1:0]  total_time;
    logic [TIME_W-1:0]  self_time;
    logic [DEPTH_W-1:0] nest_depth;
    logic [2:0]         error;
  } out_t;

endpackage

// ===== hdl/ncp_ram.sv =====
module ncp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/nested_call_profiler.sv =====
// A transaction is accepted only once the previous one is done (in_stall). For a valid
// one, the accept cycle reads the record memory and the parent stack cell (exit) or
// spills the top cell (enter), and the update writes the record back. Each result is
// registered once the output is free and waits there while the next one is read.
// Reset clears the stack pointer, the free-record count and the cached top stack cell;
// neither memory is cleared, so the block accepts transactions straight after reset.
module nested_call_profiler import ncp_pkg::*; #(
  parameter int RECORDS     = 1024,
  parameter int STACK_DEPTH = 256,
  parameter int TIME_BITS   = 48
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int REC_AW = $clog2(RECORDS);
  localparam int NF_W   = $clog2(RECORDS + 1);
  localparam int SP_W   = $clog2(STACK_DEPTH);
  localparam int CMP_W  = (NF_W > IDX_W) ? NF_W : IDX_W;
  localparam int REC_W  = COUNT_W + 2 * TIME_BITS;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  // Architectural state; the top stack cell is held in a register so that an exit
  // needs only one stack read (the parent cell).
  logic [SP_W-1:0]      stack_top_r, stack_top_nxt;
  logic [NF_W-1:0]      next_free_r, next_free_nxt;
  logic [TIME_BITS-1:0] top_cell_r, top_cell_nxt;

  // Update stage
  logic                 s1_valid_r, s1_valid_nxt;
  err_t                 s1_err_r;
  logic                 s1_exit_r;
  logic                 s1_new_r;
  logic [REC_AW-1:0]    s1_rec_r;
  logic [IDX_W-1:0]     s1_idx_r;
  logic [TIME_BITS-1:0] s1_elapsed_r;
  logic [TIME_BITS-1:0] s1_self_delta_r;

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  logic                 accept, acc_ok, done;
  err_t                 acc_err;
  logic [REC_AW-1:0]    acc_rec;
  logic [CMP_W-1:0]     idx_cmp, nf_cmp;
  logic [TIME_BITS-1:0] in_start, in_now, elapsed, self_delta;

  logic                 rec_we, rec_re;
  logic [REC_AW-1:0]    rec_addr;
  logic [REC_W-1:0]     rec_wdata, rec_rd;
  logic                 stk_we, stk_re;
  logic [SP_W-1:0]      stk_addr;
  logic [TIME_BITS-1:0] stk_rd;

  logic [COUNT_W-1:0]   cnt_old, cnt_upd;
  logic [TIME_BITS-1:0] tot_old, tot_upd, slf_old, slf_upd, parent_sum;

  assign in_stall = s1_valid_r;
  assign accept   = in_valid && !in_stall;

  assign in_start   = TIME_BITS'(in_data.start_time);
  assign in_now     = TIME_BITS'(in_data.now_time);
  assign elapsed    = in_now - in_start;
  assign self_delta = (elapsed > top_cell_r) ? (elapsed - top_cell_r) : '0;

  assign idx_cmp = CMP_W'(in_data.record_index);
  assign nf_cmp  = CMP_W'(next_free_r);

  // Stack checks take priority over record checks.
  always_comb begin
    acc_err = ERR_NONE;
    acc_rec = idx_cmp[REC_AW-1:0];
    if (!in_data.action) begin
      if (stack_top_r >= SP_W'(STACK_DEPTH - 1)) begin
        acc_err = ERR_OVERFLOW;
      end else if (in_data.is_new) begin
        if (next_free_r >= NF_W'(RECORDS)) begin
          acc_err = ERR_FULL;
        end else begin
          acc_rec = next_free_r[REC_AW-1:0];
        end
      end else if (idx_cmp >= nf_cmp) begin
        acc_err = ERR_UNKNOWN;
      end
    end else begin
      if (stack_top_r == '0) begin
        acc_err = ERR_UNDERFLOW;
      end else if (idx_cmp >= nf_cmp) begin
        acc_err = ERR_UNKNOWN;
      end
    end
  end

  assign acc_ok = accept && (acc_err == ERR_NONE);
  assign done   = s1_valid_r && (!out_valid_r || !out_stall);

  // The record memory is read in the accept cycle and written when the update
  // completes; the two never fall in the same cycle.
  assign rec_re    = acc_ok;
  assign rec_we    = done && (s1_err_r == ERR_NONE);
  assign rec_addr  = s1_valid_r ? s1_rec_r : acc_rec;
  assign rec_wdata = {cnt_upd, tot_upd, slf_upd};

  // An enter spills the cached top cell; an exit reads the parent cell.
  assign stk_we   = acc_ok && !in_data.action;
  assign stk_re   = acc_ok && in_data.action;
  assign stk_addr = in_data.action ? (stack_top_r - 1'b1) : stack_top_r;

  ncp_ram #(
    .WIDTH (REC_W),
    .DEPTH (RECORDS)
  ) u_rec_ram (
    .clk     (clk),
    .wr_en   (rec_we),
    .rd_en   (rec_re),
    .addr    (rec_addr),
    .wr_data (rec_wdata),
    .rd_data (rec_rd)
  );

  ncp_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_we),
    .rd_en   (stk_re),
    .addr    (stk_addr),
    .wr_data (top_cell_r),
    .rd_data (stk_rd)
  );

  // A freshly allocated record starts from zero whatever the memory holds.
  assign cnt_old = s1_new_r ? '0 : rec_rd[REC_W-1 -: COUNT_W];
  assign tot_old = s1_new_r ? '0 : rec_rd[2*TIME_BITS-1 -: TIME_BITS];
  assign slf_old = s1_new_r ? '0 : rec_rd[TIME_BITS-1:0];

  assign parent_sum = sat_add(stk_rd, s1_elapsed_r);

  always_comb begin
    if (s1_exit_r) begin
      cnt_upd = cnt_old;
      tot_upd = sat_add(tot_old, s1_elapsed_r);
      slf_upd = sat_add(slf_old, s1_self_delta_r);
    end else begin
      cnt_upd = (cnt_old == '1) ? cnt_old : (cnt_old + 1'b1);
      tot_upd = tot_old;
      slf_upd = slf_old;
    end
  end

  always_comb begin
    stack_top_nxt = stack_top_r;
    next_free_nxt = next_free_r;
    top_cell_nxt  = top_cell_r;
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end
    if (done) begin
      s1_valid_nxt  = 1'b0;
      out_valid_nxt = 1'b1;
      if (s1_err_r == ERR_NONE) begin
        if (s1_exit_r) begin
          stack_top_nxt = stack_top_r - 1'b1;
          top_cell_nxt  = parent_sum;
        end else begin
          stack_top_nxt = stack_top_r + 1'b1;
          top_cell_nxt  = '0;
          if (s1_new_r) begin
            next_free_nxt = next_free_r + 1'b1;
          end
        end
        out_data_nxt.record_out = IDX_W'(s1_rec_r);
        out_data_nxt.call_count = cnt_upd;
        out_data_nxt.total_time = TIME_W'(tot_upd);
        out_data_nxt.self_time  = TIME_W'(slf_upd);
      end else begin
        out_data_nxt.record_out = s1_idx_r;
        out_data_nxt.call_count = '0;
        out_data_nxt.total_time = '0;
        out_data_nxt.self_time  = '0;
      end
      out_data_nxt.nest_depth = DEPTH_W'(stack_top_nxt);
      out_data_nxt.error      = s1_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_top_r <= '0;
      next_free_r <= '0;
      top_cell_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stack_top_r <= stack_top_nxt;
      next_free_r <= next_free_nxt;
      top_cell_r  <= top_cell_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err_r        <= acc_err;
      s1_exit_r       <= in_data.action;
      s1_new_r        <= in_data.is_new && !in_data.action;
      s1_rec_r        <= acc_rec;
      s1_idx_r        <= in_data.record_index;
      s1_elapsed_r    <= elapsed;
      s1_self_delta_r <= self_delta;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_rec_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(rec_we && rec_re))
    else $error("record memory read and written in the same cycle");

  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (stack_top_r <= SP_W'(STACK_DEPTH - 1)) && (next_free_r <= NF_W'(RECORDS)))
    else $error("stack pointer or free-record count out of range");

  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    done && (s1_err_r == ERR_NONE) && !s1_exit_r |=> stack_top_r == $past(stack_top_r) + 1'b1)
    else $error("successful enter did not push the stack");

  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    done && (s1_err_r != ERR_NONE) |=>
      (stack_top_r == $past(stack_top_r)) && (next_free_r == $past(next_free_r)))
    else $error("rejected transaction changed the state");

endmodule

// ===== tb/nested_call_profiler_tb.sv =====
module nested_call_profiler_tb;
  import ncp_pkg::*;

  localparam int REC_N = 1024;
  localparam int STK_N = 256;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES = 120;
  localparam int DEEP_NEST = 48;
  localparam logic ACT_ENTER = 1'b0;
  localparam logic ACT_EXIT = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  nested_call_profiler uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  in_t pending_events[$];
  out_t predicted_stats[$];
  int unsigned total_items = 1;
  int unsigned sent = 0;
  int unsigned checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  int unsigned err_tally[5];
  int unsigned deepest = 0;

  // Predicted profiler state.
  logic [COUNT_W-1:0] p_count[REC_N];
  logic [TIME_W-1:0] p_total[REC_N];
  logic [TIME_W-1:0] p_self[REC_N];
  logic [TIME_W-1:0] p_kids[STK_N];
  int unsigned p_free = 0;
  int unsigned p_top = 0;

  // Stimulus-side view of the nesting, used only to build sensible sequences.
  int unsigned g_free = 0;
  int unsigned g_depth = 0;
  int unsigned g_rec[STK_N];
  logic [TIME_W-1:0] g_start[STK_N];
  logic [TIME_W-1:0] g_now;

  function automatic logic [TIME_W-1:0] sat_sum(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic out_t profile_event(input in_t ev);
    out_t r;
    int unsigned rec;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] kids;
    r = '0;
    r.record_out = ev.record_index;
    r.nest_depth = p_top[DEPTH_W-1:0];
    if (ev.action == ACT_ENTER) begin
      if (p_top >= STK_N - 1) begin
        r.error = ERR_OVERFLOW;
        return r;
      end
      if (ev.is_new) begin
        if (p_free >= REC_N) begin
          r.error = ERR_FULL;
          return r;
        end
        rec = p_free;
        p_free++;
        p_count[rec] = '0;
        p_total[rec] = '0;
        p_self[rec] = '0;
      end else begin
        if (ev.record_index >= p_free) begin
          r.error = ERR_UNKNOWN;
          return r;
        end
        rec = 32'(ev.record_index);
      end
      if (p_count[rec] != {COUNT_W{1'b1}}) p_count[rec]++;
      p_top++;
      p_kids[p_top] = '0;
    end else begin
      if (p_top == 0) begin
        r.error = ERR_UNDERFLOW;
        return r;
      end
      if (ev.record_index >= p_free) begin
        r.error = ERR_UNKNOWN;
        return r;
      end
      rec = 32'(ev.record_index);
      elapsed = ev.now_time - ev.start_time;
      kids = p_kids[p_top];
      p_total[rec] = sat_sum(p_total[rec], elapsed);
      p_self[rec] = sat_sum(p_self[rec], (elapsed > kids) ? elapsed - kids : {TIME_W{1'b0}});
      p_top--;
      p_kids[p_top] = sat_sum(p_kids[p_top], elapsed);
    end
    r.record_out = rec[IDX_W-1:0];
    r.call_count = p_count[rec];
    r.total_time = p_total[rec];
    r.self_time = p_self[rec];
    r.nest_depth = p_top[DEPTH_W-1:0];
    r.error = ERR_NONE;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[TIME_W-1:0];
  endfunction

  // Mostly short steps, with the odd long jump so that wide elapsed values turn up.
  function automatic logic [TIME_W-1:0] tick();
    if ($urandom_range(199) == 0) g_now = g_now + TIME_W'({$urandom_range(255), $urandom()});
    else g_now = g_now + TIME_W'($urandom_range(3000, 1));
    return g_now;
  endfunction

  function automatic in_t mk(input logic act, input logic fresh, input logic [IDX_W-1:0] idx,
                             input logic [TIME_W-1:0] t0, input logic [TIME_W-1:0] t1);
    in_t ev;
    ev.action = act;
    ev.is_new = fresh;
    ev.record_index = idx;
    ev.start_time = t0;
    ev.now_time = t1;
    return ev;
  endfunction

  function automatic in_t mk_enter(input logic fresh, input int unsigned idx);
    return mk(ACT_ENTER, fresh, idx[IDX_W-1:0], rand_time(), tick());
  endfunction

  function automatic in_t mk_exit_top();
    return mk(ACT_EXIT, 1'($urandom_range(1)), g_rec[g_depth][IDX_W-1:0], g_start[g_depth],
              tick());
  endfunction

  function automatic in_t noise_event();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(in_t)-1:0];
  endfunction

  task automatic queue_event(input in_t ev);
    pending_events.push_back(ev);
    if (ev.action == ACT_ENTER) begin
      if (g_depth < STK_N - 1) begin
        if (ev.is_new && g_free < REC_N) begin
          g_depth++;
          g_rec[g_depth] = g_free;
          g_start[g_depth] = ev.now_time;
          g_free++;
        end else if (!ev.is_new && ev.record_index < g_free) begin
          g_depth++;
          g_rec[g_depth] = 32'(ev.record_index);
          g_start[g_depth] = ev.now_time;
        end
      end
    end else if (g_depth != 0 && ev.record_index < g_free) begin
      g_depth--;
    end
  endtask

  task automatic random_step();
    int unsigned pick;
    logic fresh;
    pick = $urandom_range(99);
    if (pick < 8) begin
      queue_event(noise_event());
    end else if (pick < 12) begin
      if (g_free < REC_N) queue_event(mk_enter(1'b0, $urandom_range(REC_N - 1, g_free)));
      else queue_event(noise_event());
    end else if (g_depth == 0 || (g_depth < STK_N - 1 && $urandom_range(15) >= g_depth)) begin
      fresh = (g_free == 0) || (g_free < REC_N && $urandom_range(3) == 0);
      queue_event(mk_enter(fresh, fresh ? $urandom_range(REC_N - 1) : $urandom_range(g_free - 1)));
    end else begin
      queue_event(mk_exit_top());
    end
  endtask

  function automatic int unsigned idle_pct(input bit sender);
    int unsigned stage;
    stage = sent * 3 / total_items;
    if (stage == 0) return sender ? 7 : 57;
    if (stage == 1) return sender ? 57 : 7;
    return 0;
  endfunction

  // Sender: the prediction is made as each transaction is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predicted_stats.push_back(profile_event(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          in_data <= pending_events.pop_front();
          in_valid <= 1'b1;
          sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off of the receiver, so that the block backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && sent >= 60) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= (hold_left != 0) || ($urandom_range(99) < idle_pct(1'b0));
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: rec %0d count %0d total %0h self %0h depth %0d err %0d",
                   out_data.record_out, out_data.call_count, out_data.total_time,
                   out_data.self_time, out_data.nest_depth, out_data.error);
      end else begin
        want = predicted_stats.pop_front();
        checked++;
        if (want.error <= ERR_UNKNOWN) err_tally[want.error]++;
        if (want.nest_depth > deepest) deepest = 32'(want.nest_depth);
        if (out_data.record_out !== want.record_out || out_data.call_count !== want.call_count
            || out_data.total_time !== want.total_time || out_data.self_time !== want.self_time
            || out_data.nest_depth !== want.nest_depth || out_data.error !== want.error) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at result %0d:", checked);
            $display("  expected rec %0d count %0d total %0h self %0h depth %0d err %0d",
                     want.record_out, want.call_count, want.total_time, want.self_time,
                     want.nest_depth, want.error);
            $display("  actual   rec %0d count %0d total %0h self %0h depth %0d err %0d",
                     out_data.record_out, out_data.call_count, out_data.total_time,
                     out_data.self_time, out_data.nest_depth, out_data.error);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles,
               predicted_stats.size());
      $display("nested_call_profiler verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < STK_N; i++) p_kids[i] = '0;

    // Directed opening: empty-table and empty-stack errors, nesting, flooring and saturation.
    queue_event(mk(ACT_EXIT, 1'b0, 10'h3FF, {TIME_W{1'b1}}, {TIME_W{1'b1}}));
    queue_event(mk(ACT_ENTER, 1'b0, 10'd0, 48'd0, 48'd0));
    queue_event(mk(ACT_ENTER, 1'b1, 10'h3FF, {TIME_W{1'b1}}, 48'd1000));
    queue_event(mk(ACT_ENTER, 1'b1, 10'h155, 48'd0, 48'd1010));
    queue_event(mk(ACT_EXIT, 1'b0, 10'd1, 48'd1010, 48'd1110));
    // The parent ran for less time than its child reports, so its self time stays put.
    queue_event(mk(ACT_EXIT, 1'b0, 10'd0, 48'd1060, 48'd1110));
    queue_event(mk(ACT_ENTER, 1'b0, 10'd0, 48'd7, 48'd2000));
    // Now below start: the elapsed time wraps to the maximum and the total time saturates.
    queue_event(mk(ACT_EXIT, 1'b1, 10'd0, 48'd5, 48'd4));
    queue_event(mk(ACT_EXIT, 1'b0, 10'h2AA, 48'd0, 48'd0));
    queue_event(mk(ACT_ENTER, 1'b0, 10'd1, 48'h5555_5555_5555, 48'd3000));
    queue_event(mk(ACT_EXIT, 1'b0, 10'd7, 48'd3000, 48'd3500));
    queue_event(mk(ACT_EXIT, 1'b0, 10'd1, 48'd0, {TIME_W{1'b1}}));
    queue_event(mk(ACT_ENTER, 1'b0, 10'd2, 48'd0, 48'd0));
    queue_event(mk(ACT_ENTER, 1'b0, 10'd1, 48'd0, 48'hAAAA_AAAA_AAAA));
    queue_event(mk(ACT_EXIT, 1'b0, 10'd1, 48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA));

    g_now = 48'hFFFF_FFF8_0000 + TIME_W'($urandom_range(65535));
    repeat (260) random_step();

    // Nest well beyond the usual depth, then unwind.
    while (g_depth < DEEP_NEST) begin
      if (g_free == 0 || $urandom_range(7) == 0)
        queue_event(mk_enter(1'b1, $urandom_range(REC_N - 1)));
      else queue_event(mk_enter(1'b0, $urandom_range(g_free - 1)));
    end
    while (g_depth != 0) queue_event(mk_exit_top());
    repeat (40) random_step();

    total_items = pending_events.size();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (pending_events.size() != 0 || in_valid || predicted_stats.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d transactions checked: %0d clean, %0d overflow, %0d underflow, %0d table full,",
             checked, err_tally[ERR_NONE], err_tally[ERR_OVERFLOW], err_tally[ERR_UNDERFLOW],
             err_tally[ERR_FULL]);
    $display("%0d unknown record; deepest nesting %0d, %0d records allocated, %0d mismatches",
             err_tally[ERR_UNKNOWN], deepest, p_free, mismatches);
    if (mismatches == 0) begin
      $display("nested_call_profiler verification clean");
    end else begin
      $display("nested_call_profiler verification failed");
    end
    $finish;
  end

endmodule
